FILE: rtl/nlm_pkg.sv
// ----------------------------------------------------------------------------
// nlm_pkg: shared types and constants of the non-local means denoiser
// Default sizes, register indexes, controller/datapath command and status
// structs, and the 2^(-i/16) table of the weight approximation.
// ----------------------------------------------------------------------------
package nlm_pkg;

  localparam int DEF_MAX_WIDTH           = 256;
  localparam int DEF_MAX_HEIGHT          = 256;
  localparam int DEF_MAX_TEMPLATE_RADIUS = 3;
  localparam int DEF_MAX_SEARCH_RADIUS   = 10;
  localparam int DEF_WEIGHT_BITS         = 16;

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 24;
  localparam int PIX_W       = 8;

  localparam logic [CFG_INDEX_W-1:0] REG_FRAME_WIDTH     = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_FRAME_HEIGHT    = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_TEMPLATE_RADIUS = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_SEARCH_RADIUS   = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_DECAY_SCALE     = 3'd4;

  localparam logic [8:0]  RST_FRAME_WIDTH     = 9'd256;
  localparam logic [8:0]  RST_FRAME_HEIGHT    = 9'd256;
  localparam logic [1:0]  RST_TEMPLATE_RADIUS = 2'd3;
  localparam logic [3:0]  RST_SEARCH_RADIUS   = 4'd10;
  localparam logic [23:0] RST_DECAY_SCALE     = 24'd65536;

  localparam logic KIND_WRITE   = 1'b0;
  localparam logic KIND_COMPUTE = 1'b1;

  localparam logic [PIX_W-1:0] PIX_MAX = 8'd255;

  // log2(e) in Q.16, exponent clamp at 2^40, max base-2 shift that still counts
  localparam logic [16:0] LOG2E_Q16   = 17'd94548;
  localparam int          EXP_CLAMP_B = 40;
  localparam int          MAX_EXP_N   = 40;

  typedef struct packed {
    logic start;      // latch center, clear accumulators, reset loop counters
    logic step;       // issue one pair of frame store reads
    logic wr;         // store the input pixel
    logic div_start;  // start the weighted mean division
    logic load_out;   // load the result register
  } nlm_cmd_t;

  typedef struct packed {
    logic scan_last;   // current read pair is the last of the window
    logic pipe_empty;  // no request in flight through the weight pipe
    logic div_done;
  } nlm_stat_t;

  // round(2^24 * 2^(-i/16)), i = 0..16
  function automatic logic [24:0] pow2_neg(input logic [4:0] idx);
    logic [24:0] v;
    case (idx)
      5'd0:  v = 25'd16777216;
      5'd1:  v = 25'd16065917;
      5'd2:  v = 25'd15384775;
      5'd3:  v = 25'd14732511;
      5'd4:  v = 25'd14107901;
      5'd5:  v = 25'd13509772;
      5'd6:  v = 25'd12937002;
      5'd7:  v = 25'd12388516;
      5'd8:  v = 25'd11863283;
      5'd9:  v = 25'd11360329;
      5'd10: v = 25'd10878679;
      5'd11: v = 25'd10417458;
      5'd12: v = 25'd9975792;
      5'd13: v = 25'd9552863;
      5'd14: v = 25'd9147842;
      5'd15: v = 25'd8760003;
      5'd16: v = 25'd8388608;
      default: v = 25'd0;
    endcase
    return v;
  endfunction

endpackage

FILE: rtl/nlm_ram.sv
// ----------------------------------------------------------------------------
// nlm_ram: generic simple dual-port RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module nlm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 65536
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/nlm_ctrl.sv
// ----------------------------------------------------------------------------
// nlm_ctrl: request sequencer of the non-local means denoiser
// Accepts requests, runs the window scan, waits for the pipe to drain,
// runs the division and hands the result to the output register.
// ----------------------------------------------------------------------------
module nlm_ctrl import nlm_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  input  logic      kind,
  output logic      in_ready,
  output logic      out_valid,
  input  logic      out_ready,
  input  nlm_stat_t stat,
  output nlm_cmd_t  cmd
);

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_SCAN   = 4'b0010,
    ST_DRAIN  = 4'b0100,
    ST_DIVIDE = 4'b1000
  } state_t;

  state_t state, state_next;

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = (state == ST_IDLE);
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          if (kind == KIND_COMPUTE) begin
            cmd.start  = 1'b1;
            state_next = ST_SCAN;
          end else begin
            cmd.wr = 1'b1;
          end
        end
      end
      ST_SCAN: begin
        cmd.step = 1'b1;
        if (stat.scan_last) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (stat.pipe_empty) begin
          cmd.div_start = 1'b1;
          state_next    = ST_DIVIDE;
        end
      end
      ST_DIVIDE: begin
        // result waits here until the output register is free
        if (stat.div_done && (!out_valid || out_ready)) begin
          cmd.load_out = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_load_free: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> (!out_valid || out_ready))
    else $error("result loaded over an untaken one");

  a_rise_from_div: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == ST_DIVIDE && stat.div_done))
    else $error("result shown without a finished division");

  a_drain_div: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DRAIN && stat.pipe_empty) |=> (state == ST_DIVIDE))
    else $error("drained pipe did not start the division");
`endif

endmodule

FILE: rtl/nlm_datapath.sv
// ----------------------------------------------------------------------------
// nlm_datapath: frame store, window scan and weighted mean datapath
// Two copies of the frame store give the center and offset patch pixel in
// the same cycle; squared differences accumulate per offset, the ssd runs
// through the weight pipe, and a restoring divider forms the mean.
// ----------------------------------------------------------------------------
module nlm_datapath import nlm_pkg::*; #(
  parameter int MAX_WIDTH           = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT          = DEF_MAX_HEIGHT,
  parameter int MAX_TEMPLATE_RADIUS = DEF_MAX_TEMPLATE_RADIUS,
  parameter int MAX_SEARCH_RADIUS   = DEF_MAX_SEARCH_RADIUS,
  parameter int WEIGHT_BITS         = DEF_WEIGHT_BITS
) (
  input  logic                   clk,
  input  logic                   rst,
  input  nlm_cmd_t               cmd,
  output nlm_stat_t              stat,
  input  logic                   cfg_valid,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  input  logic [7:0]             row,
  input  logic [7:0]             column,
  input  logic [PIX_W-1:0]       pixel_value,
  output logic [PIX_W-1:0]       filtered_value
);

  localparam int MAX_DIM = (MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT;
  localparam int CW      = $clog2(MAX_DIM + 512) + 1;
  localparam int DEPTH   = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW      = $clog2(DEPTH);
  localparam int TW      = $clog2(MAX_TEMPLATE_RADIUS + 1) + 1;
  localparam int OW      = $clog2(MAX_SEARCH_RADIUS + 1) + 1;
  localparam int SSD_W   = $clog2((2*MAX_TEMPLATE_RADIUS+1)**2 * 65025 + 1);
  localparam int XP_W    = (SSD_W + 24 > EXP_CLAMP_B + 1) ? SSD_W + 24 : EXP_CLAMP_B + 1;
  localparam int X_W     = EXP_CLAMP_B + 1;
  localparam int QP_W    = X_W + 17;
  localparam int W_W     = WEIGHT_BITS + 1;
  localparam int CNT_W   = $clog2((2*MAX_SEARCH_RADIUS+1)**2 + 1);
  localparam int DEN_W   = W_W + CNT_W;
  localparam int NUM_W   = DEN_W + PIX_W;
  localparam int R_W     = NUM_W + 1;
  localparam int MAX_SH  = 26;

  // configuration registers
  logic [8:0]  frame_width, frame_height;
  logic [1:0]  template_radius;
  logic [3:0]  search_radius;
  logic [23:0] decay_scale;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width     <= RST_FRAME_WIDTH;
      frame_height    <= RST_FRAME_HEIGHT;
      template_radius <= RST_TEMPLATE_RADIUS;
      search_radius   <= RST_SEARCH_RADIUS;
      decay_scale     <= RST_DECAY_SCALE;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_FRAME_WIDTH:     frame_width     <= cfg_data[8:0];
        REG_FRAME_HEIGHT:    frame_height    <= cfg_data[8:0];
        REG_TEMPLATE_RADIUS: template_radius <= cfg_data[1:0];
        REG_SEARCH_RADIUS:   search_radius   <= cfg_data[3:0];
        REG_DECAY_SCALE:     decay_scale     <= cfg_data[23:0];
        default: ;
      endcase
    end
  end

  function automatic logic [AW-1:0] addr_of(input logic signed [CW-1:0] y,
                                            input logic signed [CW-1:0] x);
    logic [AW+CW-1:0] t;
    t = (AW+CW)'($unsigned(y)) * (AW+CW)'(MAX_WIDTH) + (AW+CW)'($unsigned(x));
    return t[AW-1:0];
  endfunction

  // radii saturate, frame size caps at the store size
  logic signed [TW-1:0] tr_sat, tr;
  logic signed [OW-1:0] sr_sat, sr;
  logic signed [CW-1:0] wcap, hcap, r0, c0;

  assign tr_sat = (int'(template_radius) > MAX_TEMPLATE_RADIUS) ?
                  TW'(MAX_TEMPLATE_RADIUS) : TW'(template_radius);
  assign sr_sat = (int'(search_radius) > MAX_SEARCH_RADIUS) ?
                  OW'(MAX_SEARCH_RADIUS) : OW'(search_radius);

  // window scan counters, tx innermost
  logic signed [TW-1:0] ty, tx;
  logic signed [OW-1:0] dy, dx;
  logic                 t_end, o_end;

  assign t_end = (tx == tr) && (ty == tr);
  assign o_end = (dx == sr) && (dy == sr);
  assign stat.scan_last = t_end && o_end;

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      tr <= tr_sat;
      sr <= sr_sat;
      ty <= -tr_sat;
      tx <= -tr_sat;
      dy <= -sr_sat;
      dx <= -sr_sat;
      r0 <= $signed(CW'(row));
      c0 <= $signed(CW'(column));
      wcap <= (int'(frame_width) > MAX_WIDTH) ? CW'(MAX_WIDTH) : $signed(CW'(frame_width));
      hcap <= (int'(frame_height) > MAX_HEIGHT) ? CW'(MAX_HEIGHT) :
              $signed(CW'(frame_height));
    end else if (cmd.step) begin
      if (tx != tr) begin
        tx <= tx + TW'(1);
      end else begin
        tx <= -tr;
        if (ty != tr) begin
          ty <= ty + TW'(1);
        end else begin
          ty <= -tr;
          if (dx != sr) begin
            dx <= dx + OW'(1);
          end else begin
            dx <= -sr;
            dy <= dy + OW'(1);
          end
        end
      end
    end
  end

  // read coordinates
  logic signed [CW-1:0] ya, xa, yb, xb;
  logic                 va, vb;

  assign ya = r0 + CW'(ty);
  assign xa = c0 + CW'(tx);
  assign yb = r0 + CW'(dy) + CW'(ty);
  assign xb = c0 + CW'(dx) + CW'(tx);
  assign va = !ya[CW-1] && !xa[CW-1] && (ya < hcap) && (xa < wcap);
  assign vb = !yb[CW-1] && !xb[CW-1] && (yb < hcap) && (xb < wcap);

  // frame store, two copies written together
  logic            wr_en;
  logic [AW-1:0]   wr_addr;
  logic [PIX_W-1:0] qa, qb;

  assign wr_en   = cmd.wr && (int'(row) < MAX_HEIGHT) && (int'(column) < MAX_WIDTH);
  assign wr_addr = addr_of($signed(CW'(row)), $signed(CW'(column)));

  nlm_ram #(.WIDTH(PIX_W), .DEPTH(DEPTH)) u_ram_center (
    .clk(clk), .we(wr_en), .waddr(wr_addr), .wdata(pixel_value),
    .raddr(addr_of(ya, xa)), .rdata(qa)
  );

  nlm_ram #(.WIDTH(PIX_W), .DEPTH(DEPTH)) u_ram_offset (
    .clk(clk), .we(wr_en), .waddr(wr_addr), .wdata(pixel_value),
    .raddr(addr_of(yb, xb)), .rdata(qb)
  );

  // read stage flags
  logic rd_vld, rd_va, rd_vb, rd_first, rd_last, rd_center;

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_vld <= 1'b0;
    end else begin
      rd_vld <= cmd.step;
    end
    rd_va     <= va;
    rd_vb     <= vb;
    rd_first  <= (tx == -tr) && (ty == -tr);
    rd_last   <= t_end;
    rd_center <= (tx == '0) && (ty == '0);
  end

  // squared difference
  logic [PIX_W-1:0] pa, pb, ad;
  logic             sq_vld, sq_first, sq_last, sq_center;
  logic [15:0]      sq;
  logic [PIX_W-1:0] sq_b;

  assign pa = rd_va ? qa : '0;
  assign pb = rd_vb ? qb : '0;
  assign ad = (pa > pb) ? pa - pb : pb - pa;

  always_ff @(posedge clk) begin
    if (rst) begin
      sq_vld <= 1'b0;
    end else begin
      sq_vld <= rd_vld;
    end
    sq        <= ad * ad;
    sq_b      <= pb;
    sq_first  <= rd_first;
    sq_last   <= rd_last;
    sq_center <= rd_center;
  end

  // ssd per offset, plus the offset center pixel
  logic [SSD_W-1:0] ssd_acc, ssd_sum, ssd_val;
  logic [PIX_W-1:0] pix_hold, ssd_pix;
  logic             ssd_vld;

  assign ssd_sum = (sq_first ? '0 : ssd_acc) + SSD_W'(sq);

  always_ff @(posedge clk) begin
    if (rst) begin
      ssd_vld <= 1'b0;
    end else begin
      ssd_vld <= sq_vld && sq_last;
    end
    if (sq_vld) begin
      ssd_acc <= ssd_sum;
      if (sq_center) begin
        pix_hold <= sq_b;
      end
    end
    ssd_val <= ssd_sum;
    ssd_pix <= sq_center ? sq_b : pix_hold;
  end

  // weight: scaled exponent with clamp
  logic [XP_W-1:0]  xp;
  logic [X_W-1:0]   x_val;
  logic [PIX_W-1:0] x_pix;
  logic             x_vld;

  assign xp = XP_W'(ssd_val) * XP_W'(decay_scale);

  always_ff @(posedge clk) begin
    if (rst) begin
      x_vld <= 1'b0;
    end else begin
      x_vld <= ssd_vld;
    end
    x_val <= (xp > (XP_W'(1) << EXP_CLAMP_B)) ? (X_W'(1) << EXP_CLAMP_B) : X_W'(xp);
    x_pix <= ssd_pix;
  end

  // base-2 exponent in Q.8
  logic [QP_W-1:0]  qp;
  logic [QP_W-33:0] q;
  logic             q_vld, q_big;
  logic [5:0]       q_n;
  logic [7:0]       q_f;
  logic [PIX_W-1:0] q_pix;

  assign qp = QP_W'(x_val) * QP_W'(LOG2E_Q16);
  assign q  = qp[QP_W-1:32];

  always_ff @(posedge clk) begin
    if (rst) begin
      q_vld <= 1'b0;
    end else begin
      q_vld <= x_vld;
    end
    q_big <= (q[QP_W-33:8] > (QP_W-40)'(MAX_EXP_N));
    q_n   <= q[13:8];
    q_f   <= q[7:0];
    q_pix <= x_pix;
  end

  // mantissa by table interpolation
  logic [24:0]      t0, t1, tdiff;
  logic [28:0]      ip;
  logic             m_vld, m_big;
  logic [24:0]      m_val;
  logic [6:0]       m_s;
  logic [PIX_W-1:0] m_pix;

  assign t0    = pow2_neg({1'b0, q_f[7:4]});
  assign t1    = pow2_neg({1'b0, q_f[7:4]} + 5'd1);
  assign tdiff = t0 - t1;
  assign ip    = 29'(tdiff) * 29'(q_f[3:0]) + 29'd8;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_vld <= 1'b0;
    end else begin
      m_vld <= q_vld;
    end
    m_val <= t0 - ip[28:4];
    m_s   <= 7'(q_n) + 7'(24 - WEIGHT_BITS);
    m_big <= q_big;
    m_pix <= q_pix;
  end

  // rounded right shift to the weight width
  logic [MAX_SH:0]  rsum;
  logic             wt_vld;
  logic [W_W-1:0]   wt_val;
  logic [PIX_W-1:0] wt_pix;

  assign rsum = (MAX_SH+1)'(m_val) + (((MAX_SH+1)'(1) << m_s) >> 1);

  always_ff @(posedge clk) begin
    if (rst) begin
      wt_vld <= 1'b0;
    end else begin
      wt_vld <= m_vld;
    end
    wt_val <= (m_big || (int'(m_s) > MAX_SH)) ? '0 : W_W'(rsum >> m_s);
    wt_pix <= m_pix;
  end

  // weighted sums
  logic               pr_vld;
  logic [W_W+PIX_W-1:0] pr_val;
  logic [W_W-1:0]     pr_w;
  logic [NUM_W-1:0]   num;
  logic [DEN_W-1:0]   den;

  always_ff @(posedge clk) begin
    if (rst) begin
      pr_vld <= 1'b0;
    end else begin
      pr_vld <= wt_vld;
    end
    pr_val <= wt_val * wt_pix;
    pr_w   <= wt_val;
    if (cmd.start) begin
      num <= '0;
      den <= '0;
    end else if (pr_vld) begin
      num <= num + NUM_W'(pr_val);
      den <= den + DEN_W'(pr_w);
    end
  end

  assign stat.pipe_empty = !(rd_vld || sq_vld || ssd_vld || x_vld || q_vld ||
                             m_vld || wt_vld || pr_vld);

  // restoring divider, 8 quotient bits, result known below 256 unless saturated
  logic [R_W-1:0]   dv_n, dv_rem, dv_dsh;
  logic [7:0]       dv_quo;
  logic [3:0]       dv_cnt;
  logic             dv_sat, dv_ge;

  assign dv_n  = R_W'(num) + R_W'(den >> 1);
  assign dv_ge = (dv_rem >= dv_dsh);

  always_ff @(posedge clk) begin
    if (rst) begin
      dv_cnt <= '0;
    end else if (cmd.div_start) begin
      dv_cnt <= (dv_n >= (R_W'(den) << 8)) ? 4'd0 : 4'd8;
    end else if (dv_cnt != '0) begin
      dv_cnt <= dv_cnt - 4'd1;
    end
    if (cmd.div_start) begin
      dv_rem <= dv_n;
      dv_dsh <= R_W'(den) << 7;
      dv_quo <= '0;
      dv_sat <= (dv_n >= (R_W'(den) << 8));
    end else if (dv_cnt != '0) begin
      if (dv_ge) begin
        dv_rem <= dv_rem - dv_dsh;
      end
      dv_quo <= {dv_quo[6:0], dv_ge};
      dv_dsh <= dv_dsh >> 1;
    end
    if (cmd.load_out) begin
      filtered_value <= dv_sat ? PIX_MAX : dv_quo;
    end
  end

  assign stat.div_done = (dv_cnt == '0);

endmodule

FILE: rtl/non_local_means_denoiser_unit.sv
// ----------------------------------------------------------------------------
// non_local_means_denoiser_unit: non-local means denoiser, top level
// Frame store plus window-scan datapath under a request sequencer.
// ----------------------------------------------------------------------------
//  channel  direction  handshake            payload
//  in       sink       in_valid/in_ready    kind, row, column, pixel_value
//  out      source     out_valid/out_ready  filtered_value
//  cfg      sink       cfg_valid/cfg_ready  cfg_index, cfg_data
//
// A compute request scans (2*sr+1)^2 * (2*tr+1)^2 read pairs, one read of
// each frame store copy per cycle, then drains the pipe and runs the division.
// Reset restores the register defaults; the frame store is not cleared.
// A new request is taken while the previous result waits on out_ready; a
// finished result waits for the output register before the next request.
// ----------------------------------------------------------------------------
module non_local_means_denoiser_unit import nlm_pkg::*; #(
  parameter int MAX_WIDTH           = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT          = DEF_MAX_HEIGHT,
  parameter int MAX_TEMPLATE_RADIUS = DEF_MAX_TEMPLATE_RADIUS,
  parameter int MAX_SEARCH_RADIUS   = DEF_MAX_SEARCH_RADIUS,
  parameter int WEIGHT_BITS         = DEF_WEIGHT_BITS
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic                   kind,
  input  logic [7:0]             row,
  input  logic [7:0]             column,
  input  logic [PIX_W-1:0]       pixel_value,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [PIX_W-1:0]       filtered_value,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  nlm_cmd_t  cmd;
  nlm_stat_t stat;

  assign cfg_ready = 1'b1;

  nlm_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .kind      (kind),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  nlm_datapath #(
    .MAX_WIDTH           (MAX_WIDTH),
    .MAX_HEIGHT          (MAX_HEIGHT),
    .MAX_TEMPLATE_RADIUS (MAX_TEMPLATE_RADIUS),
    .MAX_SEARCH_RADIUS   (MAX_SEARCH_RADIUS),
    .WEIGHT_BITS         (WEIGHT_BITS)
  ) u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .stat           (stat),
    .cfg_valid      (cfg_valid),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .row            (row),
    .column         (column),
    .pixel_value    (pixel_value),
    .filtered_value (filtered_value)
  );

endmodule

FILE: dv/non_local_means_denoiser_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// non_local_means_denoiser_unit_tb: self-checking bench for the NLM denoiser
// Fills the configured frame, then sends pixel writes and compute requests
// through a queue-fed driver. Every accepted compute request is scored by a
// local fixed-point NLM predictor and checked in order against the results.
// ----------------------------------------------------------------------------
module non_local_means_denoiser_unit_tb;
  import nlm_pkg::*;

  localparam int CYCLE_LIMIT = 1000000;
  localparam int STORE_W     = 256;
  localparam int STORE_H     = 256;

  typedef struct {
    logic       kind;
    logic [7:0] row;
    logic [7:0] column;
    logic [7:0] pix;
    bit         hold;  // wait until all results are back before sending
  } pix_req_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   in_valid = 1'b0;
  logic                   in_ready;
  logic                   kind = KIND_WRITE;
  logic [7:0]             row = '0;
  logic [7:0]             column = '0;
  logic [PIX_W-1:0]       pixel_value = '0;
  logic                   out_valid;
  logic                   out_ready = 1'b0;
  logic [PIX_W-1:0]       filtered_value;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;

  non_local_means_denoiser_unit u_dut (.*);

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // predictor state
  logic [7:0]  frame_mem [STORE_H*STORE_W];
  logic [8:0]  m_width  = RST_FRAME_WIDTH;
  logic [8:0]  m_height = RST_FRAME_HEIGHT;
  logic [1:0]  m_trad   = RST_TEMPLATE_RADIUS;
  logic [3:0]  m_srad   = RST_SEARCH_RADIUS;
  logic [23:0] m_decay  = RST_DECAY_SCALE;

  pix_req_t    req_q[$];
  logic [7:0]  filtered_q[$];
  pix_req_t    cur_req;
  int          in_gap = 0;
  int          out_stall = 0;
  bit          no_idle = 0;
  int          n_errors = 0;
  int          cycles = 0;

  localparam logic [24:0] EXP2_TAB [17] = '{
    25'd16777216, 25'd16065917, 25'd15384775, 25'd14732511, 25'd14107901,
    25'd13509772, 25'd12937002, 25'd12388516, 25'd11863283, 25'd11360329,
    25'd10878679, 25'd10417458, 25'd9975792, 25'd9552863, 25'd9147842,
    25'd8760003, 25'd8388608};

  function automatic int frame_px(int y, int x);
    int w, h;
    w = (m_width  > STORE_W) ? STORE_W : m_width;
    h = (m_height > STORE_H) ? STORE_H : m_height;
    if (y < 0 || x < 0 || y >= h || x >= w) return 0;
    return frame_mem[y*STORE_W + x];
  endfunction

  // exp(-ssd*decay/2^24) via base-2 split: integer shift plus interpolated table
  function automatic longint unsigned ssd_weight(longint unsigned ssd);
    longint unsigned x, q, n, f, hi, lo, m, s;
    x = ssd * m_decay;
    if (x > (64'd1 << 40)) x = 64'd1 << 40;
    q = (x * 64'd94548) >> 32;
    n = q >> 8;
    if (n > 40) return 0;
    f  = q & 255;
    hi = f >> 4;
    lo = f & 15;
    m  = EXP2_TAB[hi] - (((EXP2_TAB[hi] - EXP2_TAB[hi+1]) * lo + 8) >> 4);
    s  = n + 24 - DEF_WEIGHT_BITS;
    return (m + ((64'd1 << s) >> 1)) >> s;
  endfunction

  function automatic logic [7:0] denoise_pixel(int r, int c);
    int tr, sr, a, b;
    longint unsigned ssd, w, num, den, res;
    tr  = (m_trad > DEF_MAX_TEMPLATE_RADIUS) ? DEF_MAX_TEMPLATE_RADIUS : m_trad;
    sr  = (m_srad > DEF_MAX_SEARCH_RADIUS) ? DEF_MAX_SEARCH_RADIUS : m_srad;
    num = 0;
    den = 0;
    for (int dy = -sr; dy <= sr; dy++)
      for (int dx = -sr; dx <= sr; dx++) begin
        ssd = 0;
        for (int ty = -tr; ty <= tr; ty++)
          for (int tx = -tr; tx <= tr; tx++) begin
            a = frame_px(r + ty, c + tx);
            b = frame_px(r + dy + ty, c + dx + tx);
            ssd += (a - b) * (a - b);
          end
        w = ssd_weight(ssd);
        num += w * frame_px(r + dy, c + dx);
        den += w;
      end
    res = den ? (num + den / 2) / den : 0;
    return (res > 255) ? PIX_MAX : res[7:0];
  endfunction

  // driver
  always @(posedge clk) begin
    if (in_valid && in_ready) begin
      if (cur_req.kind == KIND_WRITE)
        frame_mem[cur_req.row*STORE_W + cur_req.column] = cur_req.pix;
      else
        filtered_q.push_back(denoise_pixel(cur_req.row, cur_req.column));
    end
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (in_gap > 0) begin
        in_gap--;
        in_valid <= 1'b0;
      end else if (req_q.size() > 0 && !(req_q[0].hold && filtered_q.size() > 0)) begin
        cur_req = req_q.pop_front();
        kind        <= cur_req.kind;
        row         <= cur_req.row;
        column      <= cur_req.column;
        pixel_value <= cur_req.pix;
        in_valid    <= 1'b1;
        in_gap = no_idle ? 0 : $urandom_range(0, 5);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (out_valid && out_ready) begin
      if (filtered_q.size() == 0) begin
        $error("filtered_value: unexpected result %0d", filtered_value);
        n_errors++;
      end else begin
        if (filtered_value !== filtered_q[0]) begin
          $error("filtered_value: expected %0d, got %0d", filtered_q[0], filtered_value);
          n_errors++;
        end
        void'(filtered_q.pop_front());
      end
      out_stall = no_idle ? 0 : $urandom_range(0, 5);
    end
    if (rst) begin
      out_ready <= 1'b0;
    end else if (out_stall > 0) begin
      out_stall--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL non_local_means_denoiser_unit");
      $finish;
    end
  end

  task automatic push_req(logic k, int r, int c, int p, bit hold = 0);
    pix_req_t t;
    t.kind = k;
    t.row = r;
    t.column = c;
    t.pix = p;
    t.hold = hold;
    req_q.push_back(t);
  endtask

  task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, int unsigned val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_FRAME_WIDTH:     m_width  = val;
      REG_FRAME_HEIGHT:    m_height = val;
      REG_TEMPLATE_RADIUS: m_trad   = val;
      REG_SEARCH_RADIUS:   m_srad   = val;
      REG_DECAY_SCALE:     m_decay  = val;
      default: ;
    endcase
    cfg_valid <= 1'b0;
  endtask

  task automatic wait_idle();
    while (req_q.size() > 0 || in_valid || filtered_q.size() > 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic set_frame(int w, int h, int tr, int sr, int unsigned decay);
    int we, he;
    write_reg(REG_FRAME_WIDTH, w);
    write_reg(REG_FRAME_HEIGHT, h);
    write_reg(REG_TEMPLATE_RADIUS, tr);
    write_reg(REG_SEARCH_RADIUS, sr);
    write_reg(REG_DECAY_SCALE, decay);
    we = (w > STORE_W) ? STORE_W : w;
    he = (h > STORE_H) ? STORE_H : h;
    // every entry the window can touch gets written first
    for (int r = 0; r < he; r++)
      for (int c = 0; c < we; c++)
        push_req(KIND_WRITE, r, c, $urandom_range(0, 255));
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // default radii and decay, small frame
    write_reg(REG_FRAME_WIDTH, 4);
    write_reg(REG_FRAME_HEIGHT, 4);
    for (int r = 0; r < 4; r++)
      for (int c = 0; c < 4; c++)
        push_req(KIND_WRITE, r, c, (r + c) % 2 ? 255 : $urandom_range(0, 255));
    push_req(KIND_WRITE, 3, 3, 0);
    push_req(KIND_WRITE, 255, 255, 255);  // outside frame, still stored
    push_req(KIND_COMPUTE, 0, 0, 255);
    push_req(KIND_COMPUTE, 3, 3, 0);
    push_req(KIND_COMPUTE, 255, 255, 170, 1);  // center outside the frame
    wait_idle();

    // one-pixel frame, zero radii, no decay
    no_idle = 1;
    set_frame(1, 1, 0, 0, 0);
    push_req(KIND_COMPUTE, 0, 0, 0);
    push_req(KIND_COMPUTE, 0, 1, 0);
    wait_idle();

    // oversize width and search radius saturate; strongest decay
    no_idle = 0;
    write_reg(REG_FRAME_WIDTH, 511);
    write_reg(REG_FRAME_HEIGHT, 1);
    write_reg(REG_TEMPLATE_RADIUS, 1);
    write_reg(REG_SEARCH_RADIUS, 15);
    write_reg(REG_DECAY_SCALE, 24'hFFFFFF);
    // only the columns the windows below can reach
    for (int c = 0; c < 12; c++) begin
      push_req(KIND_WRITE, 0, c, $urandom_range(0, 255));
      push_req(KIND_WRITE, 0, 255 - c, $urandom_range(0, 255));
    end
    push_req(KIND_COMPUTE, 0, 0, 0);
    push_req(KIND_COMPUTE, 0, 255, 0);
    push_req(KIND_COMPUTE, 1, 0, 0);
    wait_idle();

    // empty frame and two ignored register indexes
    write_reg(3'd7, 24'h5A5A5A);
    write_reg(3'd5, 24'hA5A5A5);
    set_frame(0, 5, 2, 2, 24'h000100);
    push_req(KIND_COMPUTE, 2, 2, 0);
    push_req(KIND_COMPUTE, 170, 85, 0);
    wait_idle();

    // random mix: mostly centers in and near the frame
    for (int ph = 0; ph < 2; ph++) begin
      no_idle = (ph == 1);
      set_frame(4, 3, $urandom_range(0, 3), $urandom_range(0, 2),
                $urandom_range(0, 24'hFFFFFF) >> $urandom_range(0, 16));
      for (int i = 0; i < 10; i++) begin
        if ($urandom_range(0, 2) == 0)
          push_req(KIND_WRITE, $urandom_range(0, 255), $urandom_range(0, 255),
                   $urandom_range(0, 255));
        else if ($urandom_range(0, 3) == 0)
          push_req(KIND_COMPUTE, $urandom_range(0, 255), $urandom_range(0, 255),
                   $urandom_range(0, 255), i == 5);
        else begin
          if ($urandom_range(0, 1))
            push_req(KIND_WRITE, $urandom_range(0, 2), $urandom_range(0, 3),
                     $urandom_range(0, 255));
          push_req(KIND_COMPUTE, $urandom_range(0, 3), $urandom_range(0, 5),
                   $urandom_range(0, 255));
        end
      end
      wait_idle();
    end

    repeat (50) @(posedge clk);
    if (n_errors == 0)
      $display("PASS non_local_means_denoiser_unit");
    else
      $display("FAIL non_local_means_denoiser_unit");
    $finish;
  end

endmodule
